/* sv/rac_pkg.sv */
// rac_pkg: shared types, constants and helpers for the range assign count block
// no dependencies
package rac_pkg;

  // storage word of the flag bitmap
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // fixed field widths
  localparam int FIELD_W    = 11;
  localparam int POP_W      = WORD_SHIFT + 1;

  // default size register value and default depth
  localparam int SIZE_RESET    = 1024;
  localparam int POSITIONS_DEF = 1024;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_COUNT   = 2'd2,
    ACT_REBUILD = 2'd3
  } act_t;

  // control handed to the word unit for the word now coming out of memory
  typedef struct packed {
    act_t                  action;
    logic                  at_lo;
    logic                  at_hi;
    logic [WORD_SHIFT-1:0] lo_bit;
    logic [WORD_SHIFT-1:0] hi_bit;
  } word_ctl_t;

  // number of set bits in one word
  function automatic logic [POP_W-1:0] popcount(input word_t w);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + POP_W'(w[i]);
    end
    return n;
  endfunction

endpackage

/* sv/rac_ram.sv */
// rac_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rac_word_unit.sv */
// rac_word_unit: shared word unit, builds the range mask for one bitmap word,
// then clears, fills, counts or rebuilds it; depends on rac_pkg
module rac_word_unit
  import rac_pkg::*;
(
  input  word_ctl_t        ctl,
  input  word_t            rd_data,
  output word_t            wr_data,
  output logic [POP_W-1:0] pop
);

  word_t lo_mask;
  word_t hi_mask;
  word_t mask;

  // mask of bits inside the range on this word
  always_comb begin
    lo_mask = ctl.at_lo ? ({WORD_BITS{1'b1}} << ctl.lo_bit) : {WORD_BITS{1'b1}};
    hi_mask = ctl.at_hi ?
              ({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - ctl.hi_bit)) :
              {WORD_BITS{1'b1}};
    mask    = lo_mask & hi_mask;
  end

  // modify or count
  always_comb begin
    case (ctl.action)
      ACT_CLEAR:   wr_data = rd_data & ~mask;
      ACT_FILL:    wr_data = rd_data | mask;
      ACT_REBUILD: wr_data = {WORD_BITS{1'b1}};
      default:     wr_data = rd_data;
    endcase
    pop = popcount(rd_data & mask);
  end

endmodule

/* sv/range_assign_count_tree.sv */
// range_assign_count_tree: one flag per position, range clear, fill, count and rebuild
// depends on rac_pkg, rac_ram, rac_word_unit
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, range_low, range_high.
//   Output channel (out_valid/out_ready) carries set_count, one result per item;
//   set_count is zero for clear, fill and rebuild.
//   cfg_write/cfg_data load size_in_use, used at the next rebuild; write only idle.
// Timing:
//   Flags are kept 32 to a memory word. A sequencer streams the words of the
//   range through one memory read port, one word per cycle, into the shared
//   word unit, which writes back or adds to the count.
//   The input transfer moves the sequencer from idle to run, which reads the
//   words of the range; a drain state lets the last word pass the unit, and
//   done loads the result into the output register. An empty range goes
//   straight from idle to done. Rebuild sweeps every word.
//   One item at a time: in_ready is high only while idle, which begins in the
//   cycle after the result is loaded.
// Reset:
//   Synchronous rst starts a sweep that sets every flag once rst falls, during
//   which no item is accepted; size_in_use resets to 1024.
// Stall:
//   A finished result waits in the output register; the block may take the next
//   item meanwhile, but holds that item's result until the register is free.
module range_assign_count_tree
  import rac_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [FIELD_W-1:0] range_low,
  input  logic [FIELD_W-1:0] range_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] set_count,
  input  logic               cfg_write,
  input  logic [FIELD_W-1:0] cfg_data
);

  localparam int WORDS     = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int EW        = AW + WORD_SHIFT;
  localparam int PW        = $clog2(POSITIONS + 1);
  localparam int XW        = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
  localparam int ACW       = (PW > POP_W) ? PW : POP_W;
  localparam int INIT_SIZE = (SIZE_RESET > POSITIONS) ? POSITIONS : SIZE_RESET;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                state;
  act_t                  act;
  logic                  booting;
  logic [FIELD_W-1:0]    size_reg;
  logic [PW-1:0]         built_size;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         p_addr;
  logic                  p_valid;
  logic [AW-1:0]         lo_w;
  logic [AW-1:0]         hi_w;
  logic [WORD_SHIFT-1:0] lo_b;
  logic [WORD_SHIFT-1:0] hi_b;
  logic [ACW-1:0]        acc;
  logic [ACW-1:0]        result;
  logic                  result_load;

  // request decode
  logic [XW-1:0]         ql, qr, sz, lo_eff, hi_eff, size_x, size_clamp;
  logic                  empty;
  logic [EW-1:0]         lo_idx, hi_idx;

  always_comb begin
    ql         = XW'(range_low);
    qr         = XW'(range_high);
    sz         = XW'(built_size);
    lo_eff     = (ql == '0) ? XW'(1) : ql;
    hi_eff     = (qr < sz) ? qr : sz;
    empty      = (ql > qr) || (lo_eff > hi_eff);
    lo_idx     = EW'(lo_eff - XW'(1));
    hi_idx     = EW'(hi_eff - XW'(1));
    size_x     = XW'(size_reg);
    size_clamp = (size_x == '0) ? XW'(1) :
                 ((size_x > XW'(POSITIONS)) ? XW'(POSITIONS) : size_x);
  end

  // bitmap memory and shared word unit
  word_t     rd_data;
  word_t     wr_data;
  word_ctl_t ctl;
  logic [POP_W-1:0] pop;
  logic      wr_en;

  always_comb begin
    ctl.action = act;
    ctl.at_lo  = (p_addr == lo_w);
    ctl.at_hi  = (p_addr == hi_w);
    ctl.lo_bit = lo_b;
    ctl.hi_bit = hi_b;
    wr_en      = p_valid && (act != ACT_COUNT);
  end

  rac_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rac_word_unit u_word (
    .ctl     (ctl),
    .rd_data (rd_data),
    .wr_data (wr_data),
    .pop     (pop)
  );

  // result goes to the output register this cycle
  assign result_load = (state == ST_DONE) && !booting && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      act        <= ACT_REBUILD;
      booting    <= 1'b1;
      size_reg   <= FIELD_W'(SIZE_RESET);
      built_size <= PW'(INIT_SIZE);
      rd_addr    <= '0;
      p_addr     <= '0;
      p_valid    <= 1'b0;
      lo_w       <= '0;
      hi_w       <= AW'(WORDS - 1);
      lo_b       <= '0;
      hi_b       <= '0;
      acc        <= '0;
      result     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        size_reg <= cfg_data;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // word read last cycle reaches the unit this cycle
      p_valid <= (state == ST_RUN);
      p_addr  <= rd_addr;
      if (p_valid && act == ACT_COUNT) begin
        acc <= acc + ACW'(pop);
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act <= act_t'(action);
            acc <= '0;
            if (act_t'(action) == ACT_REBUILD) begin
              built_size <= PW'(size_clamp);
              lo_w       <= '0;
              hi_w       <= AW'(WORDS - 1);
              rd_addr    <= '0;
              state      <= ST_RUN;
            end else if (empty) begin
              state <= ST_DONE;
            end else begin
              lo_w    <= lo_idx[EW-1:WORD_SHIFT];
              hi_w    <= hi_idx[EW-1:WORD_SHIFT];
              lo_b    <= lo_idx[WORD_SHIFT-1:0];
              hi_b    <= hi_idx[WORD_SHIFT-1:0];
              rd_addr <= lo_idx[EW-1:WORD_SHIFT];
              state   <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (rd_addr == hi_w) begin
            state <= ST_DRAIN;
          end else begin
            rd_addr <= rd_addr + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (booting) begin
            booting <= 1'b0;
            state   <= ST_IDLE;
          end else if (result_load) begin
            result <= acc;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign set_count = FIELD_W'(result);

`ifndef SYNTHESIS
  // no word in flight once idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !p_valid)
    else $error("word still in flight while idle");

  // the read address never passes the last word of the range
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rd_addr <= hi_w))
    else $error("read address beyond range");

  // a count never exceeds the number of positions
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result <= ACW'(POSITIONS)))
    else $error("count above positions");

  // memory is written only by a word that is in flight, never for a count
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (p_valid && act != ACT_COUNT && $past(state) == ST_RUN ||
               p_valid && act != ACT_COUNT && $past(state) == ST_DRAIN))
    else $error("write outside a word transfer");
`endif

endmodule

/* test/range_assign_count_tree_chk.sv */
// range_assign_count_tree_chk: watches both channels, predicts each count, compares
// depends on rac_pkg; models the flag store as a plain bitmap over positions 1..size
`timescale 1ns / 100ps
module range_assign_count_tree_chk
  import rac_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         action,
  input  logic [FIELD_W-1:0] range_low,
  input  logic [FIELD_W-1:0] range_high,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FIELD_W-1:0] set_count,
  input  logic               cfg_write,
  input  logic [FIELD_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 count_seen
);

  bit                 flag_map [1:POSITIONS];
  int                 built_size;
  logic [FIELD_W-1:0] size_reg;
  logic [FIELD_W-1:0] count_queue [$];

  // rebuild the bitmap over 1..size with every flag set, size saturated
  function automatic void rebuild_map();
    int s;
    s = size_reg;
    if (s < 1) s = 1;
    if (s > POSITIONS) s = POSITIONS;
    built_size = s;
    for (int p = 1; p <= POSITIONS; p++) flag_map[p] = (p <= s);
  endfunction

  // apply one item and return the count it yields
  function automatic logic [FIELD_W-1:0] predict_count(act_t a, int lo, int hi);
    int n;
    n = 0;
    if (a == ACT_REBUILD) begin
      rebuild_map();
    end else begin
      for (int p = (lo < 1 ? 1 : lo); p <= hi && p <= built_size; p++) begin
        case (a)
          ACT_CLEAR: flag_map[p] = 1'b0;
          ACT_FILL:  flag_map[p] = 1'b1;
          default:   n += flag_map[p];
        endcase
      end
    end
    return FIELD_W'(n);
  endfunction

  always @(posedge clk) begin
    logic [FIELD_W-1:0] want;
    if (rst) begin
      size_reg = FIELD_W'(SIZE_RESET);
      rebuild_map();
      count_queue.delete();
      fail_count = 0;
      count_seen = 0;
    end else begin
      // result transfer first: it belongs to an earlier item
      if (out_valid && out_ready) begin
        count_seen++;
        if (count_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result set_count=%0d", $time, set_count);
        end else begin
          want = count_queue.pop_front();
          if (want !== set_count) begin
            fail_count++;
            $display("%0t: set_count expected %0d actual %0d", $time, want, set_count);
          end
        end
      end
      if (in_valid && in_ready)
        count_queue.push_back(predict_count(act_t'(action), range_low, range_high));
      if (cfg_write) size_reg = cfg_data;
    end
    pending_count = count_queue.size();
  end

endmodule

/* test/range_assign_count_tree_tb.sv */
// range_assign_count_tree_tb: random and directed stimulus, verdict
// depends on rac_pkg, range_assign_count_tree, range_assign_count_tree_chk
`timescale 1ns / 100ps
module range_assign_count_tree_tb;
  import rac_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [FIELD_W-1:0] range_low = '0;
  logic [FIELD_W-1:0] range_high = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] set_count;
  logic               cfg_write = 1'b0;
  logic [FIELD_W-1:0] cfg_data = '0;
  int                 fail_count, pending_count, count_seen;
  int                 send_idle, recv_idle;
  int                 cycle_count = 0;
  int                 item_count;

  always #5 clk = ~clk;

  range_assign_count_tree u_top (.*);
  range_assign_count_tree_chk u_chk (.*);

  // receiver stall pattern
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input transfer, with random idling before it; valid is dropped by the
  // next idle cycle or drain, or replaced by the next transfer
  task automatic send_item(act_t a, int lo, int hi);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= a;
    range_low  <= FIELD_W'(lo);
    range_high <= FIELD_W'(hi);
    do @(posedge clk); while (!in_ready);
    item_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_size(int s);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= FIELD_W'(s);
    @(posedge clk);
    cfg_write <= 1'b0;
    send_item(ACT_REBUILD, $urandom_range(2047), $urandom_range(2047));
  endtask

  // mostly small in-tree ranges, some wide, some arbitrary bits
  task automatic random_item(int sz);
    int lo, hi, r;
    act_t a;
    a = act_t'($urandom_range(2));
    r = $urandom_range(99);
    if (r < 3) a = ACT_REBUILD;
    if (r < 10) begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end else if (r < 25) begin
      lo = $urandom_range(sz + 2);
      hi = $urandom_range(sz + 2);
    end else begin
      lo = $urandom_range(sz, 1);
      hi = lo + $urandom_range(40);
    end
    send_item(a, lo, hi);
  endtask

  initial begin
    int sizes [6] = '{1, 2, 1024, 37, 1023, 2047};
    send_idle = 0;
    recv_idle = 0;
    item_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, empty and outside ranges, every action
    send_item(ACT_COUNT, 1, 1024);
    send_item(ACT_CLEAR, 1, 1024);
    send_item(ACT_COUNT, 0, 2047);
    send_item(ACT_FILL, 0, 5);
    send_item(ACT_FILL, 1020, 2047);
    send_item(ACT_COUNT, 0, 2047);
    send_item(ACT_COUNT, 9, 8);
    send_item(ACT_CLEAR, 2047, 0);
    send_item(ACT_COUNT, 1025, 2047);
    send_item(ACT_FILL, 300, 700);
    send_item(ACT_CLEAR, 512, 513);
    send_item(ACT_COUNT, 1, 1024);
    send_item(ACT_COUNT, 511, 514);
    send_item(ACT_REBUILD, 2047, 2047);
    send_item(ACT_COUNT, 1024, 1024);
    write_size(0);
    send_item(ACT_COUNT, 0, 2047);
    write_size(2047);
    send_item(ACT_COUNT, 1, 2047);

    // random phases across idling patterns and sizes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 20 : (ph == 1) ? 46 : 0;
      recv_idle = (ph == 0) ? 46 : (ph == 1) ? 20 : 0;
      for (int k = 0; k < 6; k++) begin
        int sz;
        if (k == 2 && ph == 0) wait_drained();
        write_size(ph == 2 && k == 5 ? $urandom_range(2047) : sizes[(k + ph) % 6]);
        sz = (cfg_data < 1) ? 1 : (cfg_data > 1024) ? 1024 : int'(cfg_data);
        for (int i = 0; i < 107; i++) random_item(sz);
      end
    end

    wait_drained();
    $display("covered %0d items, %0d results, sizes 1..1024 and saturated writes",
             item_count, count_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
